/* rtl/efw_pkg.sv */
`timescale 1ns / 1ps
package efw_pkg;
  localparam int P_W   = 64;
  localparam int K_W   = 32;
  localparam int M_W   = 34;
  localparam int CNT_W = 7;

  localparam logic WT_A = 1'b0;
  localparam logic WT_B = 1'b1;

  typedef struct packed {
    logic             start;
    logic [P_W-1:0]   dividend;
    logic [M_W-1:0]   divisor;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [P_W-1:0] quo;
    logic [M_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic           found;
    logic           wtype;
    logic [K_W-1:0] k;
    logic [M_W-1:0] m;
    logic [K_W-1:0] d;
    logic [K_W-1:0] n;
  } res_t;
endpackage

/* rtl/efw_div.sv */
`timescale 1ns / 1ps
module efw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  efw_pkg::div_req_t req,
  output efw_pkg::div_rsp_t rsp
);
  import efw_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [M_W-1:0]   rem_r, rem_nxt;
  logic [P_W-1:0]   dq_r, dq_nxt;
  logic [M_W-1:0]   dvs_r, dvs_nxt;
  logic [M_W:0]     trial;
  logic [M_W:0]     diff;
  logic             qbit;

  always_comb begin
    trial = {rem_r, dq_r[P_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      rem_nxt  = '0;
      dq_nxt   = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[M_W-1:0] : trial[M_W-1:0];
      dq_nxt  = {dq_r[P_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dq_r;
  assign rsp.rem  = rem_r;
endmodule

/* rtl/efw_ctrl.sv */
`timescale 1ns / 1ps
module efw_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [efw_pkg::P_W-1:0]   p_in,
  input  logic [efw_pkg::K_W-1:0]   lim_in,
  input  logic                      out_free,
  input  efw_pkg::div_rsp_t         rsp,
  output efw_pkg::div_req_t         req,
  output logic                      idle,
  output logic                      res_valid,
  output efw_pkg::res_t             res
);
  import efw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_DIVK = 5'b00100,
    S_TEST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  div_req_t       req_r, req_nxt;
  logic [P_W-1:0] p_r, p_nxt;
  logic [K_W-1:0] lim_r, lim_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic [M_W-1:0] m_r, m_nxt;
  logic [M_W-1:0] r_r, r_nxt;
  logic [K_W-1:0] e_r, e_nxt;
  logic [K_W-1:0] q_r, q_nxt;
  logic           side_r, side_nxt;
  res_t           res_r, res_nxt;

  logic [K_W-1:0] s, other;
  logic [M_W-1:0] neg_b, neg_a;
  logic [M_W:0]   t4, t;

  always_comb begin
    s     = side_r ? q_r : e_r;
    other = side_r ? e_r : q_r;
    neg_b = m_r - {2'b00, s};
    t4    = {1'b0, s, 2'b00};
    t     = (t4 < {1'b0, m_r}) ? t4 : t4 - {1'b0, m_r};
    neg_a = (t == '0) ? '0 : m_r - t[M_W-1:0];

    state_nxt     = state_r;
    req_nxt       = req_r;
    req_nxt.start = 1'b0;
    p_nxt    = p_r;
    lim_nxt  = lim_r;
    k_nxt    = k_r;
    m_nxt    = m_r;
    r_nxt    = r_r;
    e_nxt    = e_r;
    q_nxt    = q_r;
    side_nxt = side_r;
    res_nxt  = res_r;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          p_nxt   = p_in;
          lim_nxt = lim_in;
          res_nxt = '0;
          if (lim_in == '0) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt   = K_W'(1);
            m_nxt   = M_W'(3);
            req_nxt = '{start: 1'b1, dividend: p_in, divisor: M_W'(3), nbits: CNT_W'(P_W)};
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (rsp.done) begin
          r_nxt   = rsp.rem;
          e_nxt   = K_W'(1);
          req_nxt = '{start: 1'b1, dividend: {k_r, {(P_W-K_W){1'b0}}},
                      divisor: M_W'(1), nbits: CNT_W'(K_W)};
          state_nxt = S_DIVK;
        end
      end
      S_DIVK: begin
        if (rsp.done) begin
          q_nxt = rsp.quo[K_W-1:0];
          if (e_r > rsp.quo[K_W-1:0]) begin
            if (k_r == lim_r) begin
              state_nxt = S_DONE;
            end else begin
              k_nxt   = k_r + 1'b1;
              m_nxt   = m_r + M_W'(4);
              req_nxt = '{start: 1'b1, dividend: p_r, divisor: m_r + M_W'(4),
                          nbits: CNT_W'(P_W)};
              state_nxt = S_MOD;
            end
          end else if (rsp.rem != '0) begin
            e_nxt   = e_r + 1'b1;
            req_nxt = '{start: 1'b1, dividend: {k_r, {(P_W-K_W){1'b0}}},
                        divisor: {2'b00, e_r + 1'b1}, nbits: CNT_W'(K_W)};
          end else begin
            side_nxt  = 1'b0;
            state_nxt = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (r_r == neg_b) begin
          res_nxt   = '{found: 1'b1, wtype: WT_B, k: k_r, m: m_r, d: other, n: s};
          state_nxt = S_DONE;
        end else if (r_r == neg_a) begin
          res_nxt   = '{found: 1'b1, wtype: WT_A, k: k_r, m: m_r, d: s, n: other};
          state_nxt = S_DONE;
        end else if (!side_r && (q_r != e_r)) begin
          side_nxt = 1'b1;
        end else begin
          e_nxt   = e_r + 1'b1;
          req_nxt = '{start: 1'b1, dividend: {k_r, {(P_W-K_W){1'b0}}},
                      divisor: {2'b00, e_r + 1'b1}, nbits: CNT_W'(K_W)};
          state_nxt = S_DIVK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      req_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      req_r     <= req_nxt;
    end
    p_r    <= p_nxt;
    lim_r  <= lim_nxt;
    k_r    <= k_nxt;
    m_r    <= m_nxt;
    r_r    <= r_nxt;
    e_r    <= e_nxt;
    q_r    <= q_nxt;
    side_r <= side_nxt;
    res_r  <= res_nxt;
  end

  assign req  = req_r;
  assign idle = (state_r == S_IDLE);
  assign res  = res_r;
endmodule

/* rtl/egyptian_fraction_witness_search.sv */
`timescale 1ns / 1ps
// Searches layers k = 1..k_limit for the first Type B / Type A congruence
// witness of a 64-bit value. All divisions run on one shared restoring
// divider, one bit per cycle: each layer takes p mod m, then one division
// per trial divisor e up to sqrt(k), then a test of each divisor found;
// an early hit ends the search.
// One beat is processed at a time; in_stall is high while a search runs.
// The finished result sits in an output register, so the next beat may be
// taken while it waits. k_limit resets to 1024; a zero limit gives an
// all-zero result.
module egyptian_fraction_witness_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [efw_pkg::P_W-1:0]      in_test_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic                         out_witness_type,
  output logic [efw_pkg::K_W-1:0]      out_layer_index,
  output logic [efw_pkg::M_W-1:0]      out_modulus,
  output logic [efw_pkg::K_W-1:0]      out_factor_d,
  output logic [efw_pkg::K_W-1:0]      out_factor_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [efw_pkg::K_W-1:0]      cfg_data
);
  import efw_pkg::*;

  logic [K_W-1:0] k_limit_r;
  logic           out_valid_r;
  res_t           out_r;
  div_req_t       req;
  div_rsp_t       rsp;
  logic           idle;
  logic           res_valid;
  res_t           res;
  logic           accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign accept    = in_valid && !in_stall;

  efw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  efw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .p_in      (in_test_value),
    .lim_in    (k_limit_r),
    .out_free  (!out_valid_r),
    .rsp       (rsp),
    .req       (req),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_limit_r   <= K_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        k_limit_r <= cfg_data;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_r.found;
  assign out_witness_type = out_r.wtype;
  assign out_layer_index  = out_r.k;
  assign out_modulus      = out_r.m;
  assign out_factor_d     = out_r.d;
  assign out_factor_n     = out_r.n;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_layer_index == '0 && out_modulus == '0
      && out_factor_d == '0 && out_factor_n == '0 && !out_witness_type)
    else $error("miss result not all zero");

  a_hit_mod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_modulus == ({2'b00, out_layer_index} << 2) - 34'd1)
    else $error("modulus does not match layer");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("beat taken while search not started");
endmodule

/* tb/sv/efw_checker.sv */
`timescale 1ns / 1ps
module efw_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [efw_pkg::P_W-1:0] in_test_value,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_found,
  input  logic                   out_witness_type,
  input  logic [efw_pkg::K_W-1:0] out_layer_index,
  input  logic [efw_pkg::M_W-1:0] out_modulus,
  input  logic [efw_pkg::K_W-1:0] out_factor_d,
  input  logic [efw_pkg::K_W-1:0] out_factor_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [efw_pkg::K_W-1:0] cfg_data,
  output int                     n_errors,
  output int                     n_pending,
  output int                     n_witnesses
);
  import efw_pkg::*;

  logic [K_W-1:0] layer_limit;
  res_t           witness_q[$];

  function automatic longint unsigned neg_mod(longint unsigned v, longint unsigned md);
    longint unsigned t;
    t = v % md;
    return (t == 0) ? 0 : md - t;
  endfunction

  function automatic res_t search_witness(logic [P_W-1:0] p, logic [K_W-1:0] lim);
    res_t            res;
    longint unsigned k, md, r, e, s;
    longint unsigned divs[2];
    int              cnt;
    res = '0;
    for (k = 1; k <= lim; k++) begin
      md = 4 * k - 1;
      r  = p % md;
      for (e = 1; e <= k / e; e++) begin
        if (k % e != 0) continue;
        divs[0] = e;
        divs[1] = k / e;
        cnt = (divs[0] == divs[1]) ? 1 : 2;
        for (int i = 0; i < cnt; i++) begin
          s = divs[i];
          if (r == neg_mod(s, md)) begin
            res.found = 1'b1; res.wtype = WT_B; res.k = k[K_W-1:0];
            res.m = md[M_W-1:0]; res.d = K_W'(k / s); res.n = s[K_W-1:0];
            return res;
          end
          if (r == neg_mod((4 * s) % md, md)) begin
            res.found = 1'b1; res.wtype = WT_A; res.k = k[K_W-1:0];
            res.m = md[M_W-1:0]; res.d = s[K_W-1:0]; res.n = K_W'(k / s);
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      layer_limit <= K_W'(1024);
      n_errors    <= 0;
      n_witnesses <= 0;
      witness_q.delete();
      n_pending   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) layer_limit <= cfg_data;
      if (in_valid && !in_stall) witness_q.push_back(search_witness(in_test_value, layer_limit));
      if (out_valid && !out_stall) begin
        got = '{out_found, out_witness_type, out_layer_index, out_modulus,
                out_factor_d, out_factor_n};
        if (witness_q.size() == 0) begin
          if (n_errors < 10) $display("ERROR: unexpected result beat %p", got);
          n_errors <= n_errors + 1;
        end else begin
          want = witness_q.pop_front();
          if (got.found) n_witnesses <= n_witnesses + 1;
          if (got.found != want.found || got.wtype != want.wtype || got.k != want.k ||
              got.m != want.m || got.d != want.d || got.n != want.n) begin
            if (n_errors < 10) $display("ERROR: expected %p got %p", want, got);
            n_errors <= n_errors + 1;
          end
        end
      end
      n_pending <= witness_q.size();
    end
  end
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import efw_pkg::*;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [P_W-1:0] in_test_value = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic           out_found, out_witness_type;
  logic [K_W-1:0] out_layer_index, out_factor_d, out_factor_n;
  logic [M_W-1:0] out_modulus;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [K_W-1:0] cfg_data = '0;
  int             n_errors, n_pending, n_witnesses;
  int             n_sent = 0, n_cfg = 0, stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  egyptian_fraction_witness_search i_dut (.*);
  efw_checker i_chk (.*);

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  task automatic send_value(logic [P_W-1:0] p);
    int gap;
    in_valid      <= 1'b1;
    in_test_value <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_limit(logic [K_W-1:0] lim);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    @(posedge clk);
  endtask

  // p = 2 mod 3 always hits at the first layer
  function automatic logic [P_W-1:0] first_layer_hit();
    logic [P_W-1:0] p;
    p = {$urandom, $urandom} >> 1;
    return p - (p % 3) + 2;
  endfunction

  initial begin
    logic [P_W-1:0] p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of 1024: only early hits
    send_value(64'hFFFF_FFFF_FFFF_FFFE);
    send_value(64'd2);
    send_value(first_layer_hit());
    write_limit(32'hFFFF_FFFF);
    send_value(first_layer_hit());
    send_value(64'd5);
    write_limit('0);
    send_value('0);
    send_value('1);
    send_value(64'd2);
    write_limit(32'd1);
    send_value('0);
    send_value('1);
    send_value(64'd2);
    send_value(64'd4);
    write_limit(32'd60);
    send_value('0);
    send_value('1);
    send_value(64'd1);
    send_value(64'h8000_0000_0000_0000);
    for (int i = 0; i < 5; i++) send_value({$urandom, $urandom});

    for (int i = 0; i < 100; i++) begin
      if (i % 20 == 0)
        write_limit(($urandom_range(0, 9) == 0) ? $urandom_range(41, 100)
                                                 : $urandom_range(1, 40));
      case ($urandom_range(0, 3))
        0: p = {$urandom, $urandom} >> $urandom_range(0, 63);
        1: p = $urandom_range(0, 500);
        default: p = {$urandom, $urandom};
      endcase
      send_value(p);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d test values over %0d limit settings, %0d witnesses found.",
             n_sent, n_cfg, n_witnesses);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
